@@ hdl/npsi_pkg.sv @@
// Shared types, constants and helper functions of the permute source index unit.
package npsi_pkg;

	// Hardware sizes.
	localparam int MAX_DIMS      = 4;
	localparam int NUM_DIMS      = 4;
	localparam int DIM_CAP       = (MAX_DIMS < NUM_DIMS) ? MAX_DIMS : NUM_DIMS;
	localparam int INDEX_BITS    = 24;
	localparam int SHAPE_BITS    = 16;
	localparam int STRIDE_BITS   = 24;
	localparam int ELEMENT_BYTES = 4;
	localparam int BYTE_BITS     = 26;
	localparam int COUNT_BITS    = 3;
	localparam int ORDER_BITS    = 8;
	localparam int SHAPE_ALL     = SHAPE_BITS * NUM_DIMS;
	localparam int PROD_BITS     = INDEX_BITS + STRIDE_BITS;
	localparam int PAIR_BITS     = PROD_BITS + 1;
	localparam int SUM_BITS      = PROD_BITS + 2;
	localparam int DIV_STEPS     = INDEX_BITS * (NUM_DIMS - 1);

	// Register indexes of the configuration port.
	localparam logic [2:0] REG_DIM_COUNT    = 3'd0;
	localparam logic [2:0] REG_TARGET_SHAPE = 3'd1;
	localparam logic [2:0] REG_DIM_ORDER    = 3'd2;
	localparam logic [2:0] REG_STRIDE_0     = 3'd3;
	localparam logic [2:0] REG_STRIDE_1     = 3'd4;
	localparam logic [2:0] REG_STRIDE_2     = 3'd5;

	// One stage of the divider chain: running quotient/dividend, partial
	// remainder, and the coordinates of dimensions 1 and up found so far.
	typedef struct packed {
		logic [INDEX_BITS-1:0]                  q;
		logic [SHAPE_BITS-1:0]                  r;
		logic [NUM_DIMS-1:1][SHAPE_BITS-1:0]    c;
	} div_stage_t;

	// Number of dimensions in use after clamping.
	function automatic logic [COUNT_BITS-1:0] eff_dims(input logic [COUNT_BITS-1:0] cnt);
		logic [COUNT_BITS-1:0] n;
		n = cnt;
		if (n == '0)
			n = COUNT_BITS'(1);
		if (n > COUNT_BITS'(DIM_CAP))
			n = COUNT_BITS'(DIM_CAP);
		return n;
	endfunction

endpackage

@@ hdl/npsi_div_step.sv @@
// One registered step of the restoring divider: one quotient bit per stage.
module npsi_div_step (
	input  logic                               clk,
	input  logic                               arst_n,
	input  logic                               en,
	input  logic                               vld_in,
	input  npsi_pkg::div_stage_t               st_in,
	input  logic [npsi_pkg::SHAPE_BITS-1:0]    divisor,
	output logic                               vld_out,
	output npsi_pkg::div_stage_t               st_out
);
	import npsi_pkg::*;

	logic [SHAPE_BITS:0]   trial;
	logic                  ge;
	div_stage_t            nxt;

	// The partial remainder stays below the divisor, so the trial value
	// fits one bit above the divisor width.
	always_comb begin
		trial  = {st_in.r, st_in.q[INDEX_BITS-1]};
		ge     = trial >= {1'b0, divisor};
		nxt    = st_in;
		nxt.q  = {st_in.q[INDEX_BITS-2:0], ge};
		nxt.r  = ge ? SHAPE_BITS'(trial - {1'b0, divisor}) : trial[SHAPE_BITS-1:0];
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			vld_out <= 1'b0;
		end else if (en) begin
			vld_out <= vld_in;
		end
	end

	always_ff @(posedge clk) begin
		if (en) begin
			st_out <= nxt;
		end
	end

endmodule

@@ hdl/npsi_dot.sv @@
// Stride products and their sum, with truncation and overflow, in three stages.
module npsi_dot (
	input  logic                                                   clk,
	input  logic                                                   arst_n,
	input  logic                                                   en,
	input  logic                                                   vld_in,
	input  logic [npsi_pkg::NUM_DIMS-1:0][npsi_pkg::INDEX_BITS-1:0] coord,
	input  logic [npsi_pkg::COUNT_BITS-1:0]                        n_dims,
	input  logic [npsi_pkg::ORDER_BITS-1:0]                        dim_order,
	input  logic [npsi_pkg::NUM_DIMS-2:0][npsi_pkg::STRIDE_BITS-1:0] strides,
	output logic                                                   vld_out,
	output logic [npsi_pkg::INDEX_BITS-1:0]                        source_index,
	output logic [npsi_pkg::BYTE_BITS-1:0]                         byte_offset,
	output logic                                                   overflow
);
	import npsi_pkg::*;

	logic [NUM_DIMS-2:0][PROD_BITS-1:0] term_c;
	logic [INDEX_BITS-1:0]              last_c;
	logic [1:0]                         last_ent;
	logic [NUM_DIMS-2:0][PROD_BITS-1:0] term_s1;
	logic [INDEX_BITS-1:0]              last_s1;
	logic [PAIR_BITS-1:0]               pa_s2;
	logic [PAIR_BITS-1:0]               pb_s2;
	logic [SUM_BITS-1:0]                sum_c;
	logic                               vld_s1;
	logic                               vld_s2;

	// Entry i picks the coordinate that pairs with stride i; the last entry
	// in use is added without a stride. Unused coordinates are zero.
	always_comb begin
		for (int i = 0; i < NUM_DIMS - 1; i++) begin
			if (COUNT_BITS'(i + 1) < n_dims)
				term_c[i] = PROD_BITS'(coord[dim_order[2*i +: 2]]) * PROD_BITS'(strides[i]);
			else
				term_c[i] = '0;
		end
		last_ent = 2'(n_dims - COUNT_BITS'(1));
		last_c   = coord[dim_order[2*last_ent +: 2]];
	end

	assign sum_c = SUM_BITS'(pa_s2) + SUM_BITS'(pb_s2);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			vld_s1  <= 1'b0;
			vld_s2  <= 1'b0;
			vld_out <= 1'b0;
		end else if (en) begin
			vld_s1  <= vld_in;
			vld_s2  <= vld_s1;
			vld_out <= vld_s2;
		end
	end

	always_ff @(posedge clk) begin
		if (en) begin
			term_s1      <= term_c;
			last_s1      <= last_c;
			pa_s2        <= PAIR_BITS'(term_s1[0]) + PAIR_BITS'(term_s1[1]);
			pb_s2        <= PAIR_BITS'(term_s1[2]) + PAIR_BITS'(last_s1);
			source_index <= sum_c[INDEX_BITS-1:0];
			byte_offset  <= BYTE_BITS'(sum_c[INDEX_BITS-1:0] * ELEMENT_BYTES);
			overflow     <= |sum_c[SUM_BITS-1:INDEX_BITS];
		end
	end

endmodule

@@ hdl/nd_permute_source_index_unit.sv @@
// Top level of the N-dimensional permute source index unit.
// This unit turns the linear index of an output element of a permute into the
// linear index of the source element to copy, its byte offset, and an
// overflow flag when the exact source index does not fit 24 bits. It takes
// one transaction per cycle while in_stall is low and delivers one result
// per input transaction in order, through 72 stages of a restoring divider (one
// quotient bit per stage, 24 stages for each of dimensions 3, 2 and 1, an
// unused dimension dividing by one) and three stages of stride products and
// summation. The whole pipeline advances while the output register is empty
// or being taken; while it is held, one further transaction is parked in an
// input skid register, and in_stall rises until that register has drained.
// Configuration writes are always taken (cfg_ready is tied high) and must
// only be issued while the unit is empty.
module nd_permute_source_index_unit (
	input  logic                                 clk,
	input  logic                                 arst_n,
	input  logic                                 in_valid,
	output logic                                 in_stall,
	input  logic [npsi_pkg::INDEX_BITS-1:0]      out_index,
	output logic                                 out_valid,
	input  logic                                 out_stall,
	output logic [npsi_pkg::INDEX_BITS-1:0]      source_index,
	output logic [npsi_pkg::BYTE_BITS-1:0]       byte_offset,
	output logic                                 overflow,
	input  logic                                 cfg_valid,
	output logic                                 cfg_ready,
	input  logic [2:0]                           cfg_index,
	input  logic [npsi_pkg::SHAPE_ALL-1:0]       cfg_data
);
	import npsi_pkg::*;

	// Configuration registers.
	logic [COUNT_BITS-1:0]                   dim_count_q;
	logic [SHAPE_ALL-1:0]                    target_shape_q;
	logic [ORDER_BITS-1:0]                   dim_order_q;
	logic [NUM_DIMS-2:0][STRIDE_BITS-1:0]    stride_q;

	logic [COUNT_BITS-1:0]                   n_dims;
	logic [NUM_DIMS-1:1][SHAPE_BITS-1:0]     div_dim;

	// Input skid register.
	logic                                    skid_valid_q;
	logic [INDEX_BITS-1:0]                   skid_idx_q;

	logic                                    en;
	logic                                    in_acc;

	logic                                    vld_in_w  [DIV_STEPS];
	logic                                    vld_out_w [DIV_STEPS];
	div_stage_t                              st_in_w   [DIV_STEPS];
	div_stage_t                              st_out_w  [DIV_STEPS];

	logic [NUM_DIMS-1:0][INDEX_BITS-1:0]     coord;

	assign cfg_ready = 1'b1;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			dim_count_q    <= COUNT_BITS'(1);
			target_shape_q <= {NUM_DIMS{SHAPE_BITS'(1)}};
			dim_order_q    <= 8'hE4;
			stride_q       <= {(NUM_DIMS-1){STRIDE_BITS'(1)}};
		end else if (cfg_valid && cfg_ready) begin
			unique case (cfg_index)
				REG_DIM_COUNT:    dim_count_q    <= cfg_data[COUNT_BITS-1:0];
				REG_TARGET_SHAPE: target_shape_q <= cfg_data;
				REG_DIM_ORDER:    dim_order_q    <= cfg_data[ORDER_BITS-1:0];
				REG_STRIDE_0:     stride_q[0]    <= cfg_data[STRIDE_BITS-1:0];
				REG_STRIDE_1:     stride_q[1]    <= cfg_data[STRIDE_BITS-1:0];
				REG_STRIDE_2:     stride_q[2]    <= cfg_data[STRIDE_BITS-1:0];
				default: begin
				end
			endcase
		end
	end

	// A zero size counts as one, and a dimension beyond the count in use
	// divides by one, which leaves its coordinate at zero.
	always_comb begin
		n_dims = eff_dims(dim_count_q);
		for (int i = 1; i < NUM_DIMS; i++) begin
			div_dim[i] = target_shape_q[SHAPE_BITS*i +: SHAPE_BITS];
			if (div_dim[i] == '0 || COUNT_BITS'(i) >= n_dims)
				div_dim[i] = SHAPE_BITS'(1);
		end
	end

	// The pipeline moves unless a finished result is being held.
	assign en       = !(out_valid && out_stall);
	assign in_stall = skid_valid_q;
	assign in_acc   = in_valid && !in_stall;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			skid_valid_q <= 1'b0;
		end else if (en) begin
			skid_valid_q <= 1'b0;
		end else if (in_acc) begin
			skid_valid_q <= 1'b1;
		end
	end

	always_ff @(posedge clk) begin
		if (!en && in_acc) begin
			skid_idx_q <= out_index;
		end
	end

	// Divider chain. Each group of INDEX_BITS stages divides by one
	// dimension size, outermost-but-one last; at a group boundary the
	// remainder becomes that dimension's coordinate and the quotient is
	// the next dividend.
	for (genvar j = 0; j < DIV_STEPS; j++) begin : g_div
		localparam int K = j / INDEX_BITS;
		localparam int B = j % INDEX_BITS;

		if (j == 0) begin : g_entry
			always_comb begin
				vld_in_w[j]   = skid_valid_q || in_acc;
				st_in_w[j]    = '0;
				st_in_w[j].q  = skid_valid_q ? skid_idx_q : out_index;
			end
		end else if (B == 0) begin : g_handoff
			always_comb begin
				vld_in_w[j]                = vld_out_w[j-1];
				st_in_w[j]                 = st_out_w[j-1];
				st_in_w[j].r               = '0;
				st_in_w[j].c[NUM_DIMS - K] = st_out_w[j-1].r;
			end
		end else begin : g_chain
			assign vld_in_w[j] = vld_out_w[j-1];
			assign st_in_w[j]  = st_out_w[j-1];
		end

		npsi_div_step u_step (
			.clk     (clk),
			.arst_n  (arst_n),
			.en      (en),
			.vld_in  (vld_in_w[j]),
			.st_in   (st_in_w[j]),
			.divisor (div_dim[NUM_DIMS - 1 - K]),
			.vld_out (vld_out_w[j]),
			.st_out  (st_out_w[j])
		);
	end

	// The outermost coordinate is the whole remaining quotient.
	always_comb begin
		coord[0] = st_out_w[DIV_STEPS-1].q;
		coord[1] = INDEX_BITS'(st_out_w[DIV_STEPS-1].r);
		for (int i = 2; i < NUM_DIMS; i++)
			coord[i] = INDEX_BITS'(st_out_w[DIV_STEPS-1].c[i]);
	end

	npsi_dot u_dot (
		.clk          (clk),
		.arst_n       (arst_n),
		.en           (en),
		.vld_in       (vld_out_w[DIV_STEPS-1]),
		.coord        (coord),
		.n_dims       (n_dims),
		.dim_order    (dim_order_q),
		.strides      (stride_q),
		.vld_out      (out_valid),
		.source_index (source_index),
		.byte_offset  (byte_offset),
		.overflow     (overflow)
	);

endmodule

@@ hdl/npsi_checker.sv @@
// Port-level checker of the permute source index unit and its bind.
module npsi_checker (
	input logic                                 clk,
	input logic                                 arst_n,
	input logic                                 out_valid,
	input logic                                 out_stall,
	input logic [npsi_pkg::INDEX_BITS-1:0]      source_index,
	input logic [npsi_pkg::BYTE_BITS-1:0]       byte_offset,
	input logic                                 cfg_valid,
	input logic                                 cfg_ready
);
	import npsi_pkg::*;

	// A held result stays offered.
	a_out_hold: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && out_stall |=> out_valid)
		else $error("result transaction dropped while stalled");

	// A held result keeps its source index.
	a_out_stable: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && out_stall |=> $stable(source_index))
		else $error("result transaction changed while stalled");

	// While a result is offered, the byte offset follows from the truncated source index.
	a_byte: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid |-> byte_offset == BYTE_BITS'(source_index * ELEMENT_BYTES))
		else $error("byte offset does not match source index");

	// Configuration writes are never refused.
	a_cfg: assert property (@(posedge clk) disable iff (!arst_n)
		cfg_valid |-> cfg_ready)
		else $error("configuration write refused");

endmodule

bind nd_permute_source_index_unit npsi_checker u_npsi_checker (
	.clk          (clk),
	.arst_n       (arst_n),
	.out_valid    (out_valid),
	.out_stall    (out_stall),
	.source_index (source_index),
	.byte_offset  (byte_offset),
	.cfg_valid    (cfg_valid),
	.cfg_ready    (cfg_ready)
);
